>>> src/hde_pkg.sv
// Package for the harsh driving event detector.
// Holds the item, result, state and configuration types and the fixed constants.
// No dependencies.
package hde_pkg;

	localparam int unsigned SpeedW   = 8;
	localparam int unsigned CourseW  = 9;
	localparam int unsigned TurnLimW = 16;
	localparam int unsigned FixCntW  = 3;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	localparam logic [SpeedW-1:0]  TurnMinSpeed = 8'd25;
	localparam logic [SpeedW-1:0]  BandStep1    = 8'd30;
	localparam logic [SpeedW-1:0]  BandStep2    = 8'd60;
	localparam logic [SpeedW-1:0]  TopBandSpeed = 8'd90;
	localparam logic [CourseW-1:0] HalfCircle   = 9'd180;
	localparam logic [CourseW-1:0] FullCircle   = 9'd360;
	localparam logic [FixCntW-1:0] FixQualify   = 3'd5;
	localparam logic [FixCntW-1:0] FixCountMax  = 3'd7;
	localparam logic [TurnLimW-1:0] TurnLimReset = 16'd15;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ACCEL_BAND0 = 3'd0,
		REG_ACCEL_BAND1 = 3'd1,
		REG_ACCEL_BAND2 = 3'd2,
		REG_ACCEL_BAND3 = 3'd3,
		REG_DECEL_LOW   = 3'd4,
		REG_DECEL_HIGH  = 3'd5,
		REG_TURN_LIMIT  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [SpeedW-1:0]  pulse_speed;
		logic [SpeedW-1:0]  gps_speed;
		logic               gps_fixed;
		logic [CourseW-1:0] course_deg;
		logic               ignition_on;
		logic               navigation_ok;
		logic               vehicle_moving;
		logic               obd_module_present;
	} item_t;

	typedef struct packed {
		logic              sharp_accel;
		logic              sharp_decel;
		logic              sharp_turn;
		logic [SpeedW-1:0] current_speed;
		logic              speed_trusted;
	} result_t;

	typedef struct packed {
		logic [SpeedW-1:0]  accel_prev_speed;
		logic [SpeedW-1:0]  decel_prev_speed;
		logic [CourseW-1:0] prev_course;
		logic               speed_valid;
		logic [FixCntW-1:0] fix_count;
	} state_t;

	typedef struct packed {
		logic [3:0][SpeedW-1:0] accel_limit;
		logic [SpeedW-1:0]      decel_limit_low;
		logic [SpeedW-1:0]      decel_limit_high;
		logic [TurnLimW-1:0]    turn_angle_limit;
	} cfg_t;

endpackage

>>> src/hde_cfg_regs.sv
// Configuration register file of the harsh driving event detector.
// Depends on hde_pkg for the register indexes and the cfg_t type.
module hde_cfg_regs import hde_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [CfgIdxW-1:0]  wr_index,
	input  logic [CfgDataW-1:0] wr_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{accel_limit: '0, decel_limit_low: '0, decel_limit_high: '0,
				turn_angle_limit: TurnLimReset};
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_ACCEL_BAND0: cfg_q.accel_limit[0] <= wr_data[SpeedW-1:0];
				REG_ACCEL_BAND1: cfg_q.accel_limit[1] <= wr_data[SpeedW-1:0];
				REG_ACCEL_BAND2: cfg_q.accel_limit[2] <= wr_data[SpeedW-1:0];
				REG_ACCEL_BAND3: cfg_q.accel_limit[3] <= wr_data[SpeedW-1:0];
				REG_DECEL_LOW:   cfg_q.decel_limit_low <= wr_data[SpeedW-1:0];
				REG_DECEL_HIGH:  cfg_q.decel_limit_high <= wr_data[SpeedW-1:0];
				REG_TURN_LIMIT:  cfg_q.turn_angle_limit <= wr_data[TurnLimW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/hde_eval.sv
// Per-word evaluation: speed qualification, the three event tests and the next state.
// Purely combinational; depends on hde_pkg.
module hde_eval import hde_pkg::*; (
	input  item_t   item,
	input  state_t  cur,
	input  cfg_t    cfg,
	output result_t res,
	output state_t  nxt
);

	logic [SpeedW-1:0]  speed;
	logic               valid_new;
	logic [FixCntW-1:0] fix_new;
	logic               acc_off;
	logic               dec_off;
	logic [SpeedW-1:0]  acc_old;
	logic [SpeedW-1:0]  dec_old;
	logic [1:0]         band;
	logic [SpeedW-1:0]  acc_lim;
	logic [SpeedW-1:0]  dec_lim;
	logic [CourseW-1:0] diff;
	logic [CourseW-1:0] change;
	logic               acc_ev;
	logic               dec_ev;
	logic               turn_ev;

	always_comb begin
		speed = (item.pulse_speed != '0) ? item.pulse_speed : item.gps_speed;

		valid_new = cur.speed_valid;
		fix_new   = cur.fix_count;
		if (item.pulse_speed != '0) begin
			valid_new = 1'b1;
		end else if (!item.gps_fixed) begin
			valid_new = 1'b0;
			fix_new   = '0;
		end else if (!cur.speed_valid) begin
			if (cur.fix_count > FixQualify) begin
				valid_new = 1'b1;
			end
			if (cur.fix_count < FixCountMax) begin
				fix_new = cur.fix_count + 1'b1;
			end
		end

		acc_off = (cfg.accel_limit[0] == '0) || (cfg.accel_limit[1] == '0) ||
			(cfg.accel_limit[2] == '0) || (cfg.accel_limit[3] == '0);
		dec_off = (cfg.decel_limit_low == '0) || (cfg.decel_limit_high == '0);

		acc_old = cur.accel_prev_speed;
		if (acc_old >= TopBandSpeed) begin
			band = 2'd3;
		end else if (acc_old >= BandStep2) begin
			band = 2'd2;
		end else if (acc_old >= BandStep1) begin
			band = 2'd1;
		end else begin
			band = 2'd0;
		end
		acc_lim = cfg.accel_limit[band];
		acc_ev  = !acc_off && valid_new && (speed > acc_old) && (acc_old != '0) &&
			((speed - acc_old) >= acc_lim);

		dec_old = cur.decel_prev_speed;
		dec_lim = (dec_old < BandStep1) ? cfg.decel_limit_low : cfg.decel_limit_high;
		dec_ev  = !dec_off && valid_new && (speed < dec_old) && (dec_old != '0) &&
			((dec_old - speed) >= dec_lim);

		diff = (item.course_deg >= cur.prev_course) ? item.course_deg - cur.prev_course
			: cur.prev_course - item.course_deg;
		if (diff < HalfCircle) begin
			change = diff;
		end else if (diff <= FullCircle) begin
			change = FullCircle - diff;
		end else begin
			change = '0;
		end
		turn_ev = (cfg.turn_angle_limit != '0) && item.ignition_on && item.navigation_ok &&
			item.vehicle_moving && (speed > TurnMinSpeed) &&
			({{(TurnLimW-CourseW){1'b0}}, change} >= cfg.turn_angle_limit);

		nxt = cur;
		res.current_speed = speed;
		if (item.obd_module_present) begin
			res.sharp_accel   = 1'b0;
			res.sharp_decel   = 1'b0;
			res.sharp_turn    = 1'b0;
			res.speed_trusted = cur.speed_valid;
		end else begin
			res.sharp_accel   = acc_ev;
			res.sharp_decel   = dec_ev;
			res.sharp_turn    = turn_ev;
			res.speed_trusted = valid_new;
			nxt.speed_valid   = valid_new;
			nxt.fix_count     = fix_new;
			if (!acc_off) begin
				nxt.accel_prev_speed = speed;
			end
			if (!dec_off) begin
				nxt.decel_prev_speed = speed;
			end
			if (cfg.turn_angle_limit != '0) begin
				nxt.prev_course = item.course_deg;
			end
		end
	end

endmodule

>>> src/harsh_driving_event_detector.sv
// Top level of the harsh driving event detector: input register, evaluation, result register.
// Depends on hde_pkg, hde_cfg_regs and hde_eval.
//
//  channel  handshake               payload
//  in       in_valid / in_stall     pulse_speed .. obd_module_present
//  out      out_valid / out_stall   sharp_accel .. speed_trusted
//  cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One word is accepted per cycle unless stalled; it passes the input and result registers.
// The evaluation of a word and the update of the tracking state share one cycle.
// A stalled result is held in the output register while the input register still takes a word.
// Reset clears the tracking state, the valid flags and the configuration registers; turn_angle_limit resets to 15.
// Configuration writes are always accepted.
module harsh_driving_event_detector import hde_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SpeedW-1:0]   pulse_speed,
	input  logic [SpeedW-1:0]   gps_speed,
	input  logic                gps_fixed,
	input  logic [CourseW-1:0]  course_deg,
	input  logic                ignition_on,
	input  logic                navigation_ok,
	input  logic                vehicle_moving,
	input  logic                obd_module_present,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                sharp_accel,
	output logic                sharp_decel,
	output logic                sharp_turn,
	output logic [SpeedW-1:0]   current_speed,
	output logic                speed_trusted,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_comb;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;
	logic    accept;

	assign cfg_ready = 1'b1;

	hde_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{pulse_speed, gps_speed, gps_fixed, course_deg, ignition_on,
				navigation_ok, vehicle_moving, obd_module_present};
		end
	end

	hde_eval u_eval (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg),
		.res  (res_comb),
		.nxt  (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_comb;
		end
	end

	assign out_valid     = out_valid_q;
	assign sharp_accel   = res_q.sharp_accel;
	assign sharp_decel   = res_q.sharp_decel;
	assign sharp_turn    = res_q.sharp_turn;
	assign current_speed = res_q.current_speed;
	assign speed_trusted = res_q.speed_trusted;

	a_event_needs_trust: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (sharp_accel || sharp_decel) |-> speed_trusted)
		else $error("speed event reported on untrusted speed");

	a_turn_needs_speed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sharp_turn |-> current_speed > TurnMinSpeed)
		else $error("turn event reported below the turn speed");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with room in the pipeline");

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for harsh_driving_event_detector: a queue-fed driver, a result monitor
// and an in-bench predictor of the event flags, speed and trust, run over several limit settings.
// Depends on hde_pkg and the detector RTL.
module tb;
	import hde_pkg::*;

	localparam int unsigned WatchdogLimit = 1000;
	localparam int unsigned SettleCycles  = 4;
	localparam int unsigned RandomPhases  = 9;
	localparam int unsigned PhaseTicks    = 64;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	item_t cur_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic sharp_accel;
	logic sharp_decel;
	logic sharp_turn;
	logic [SpeedW-1:0] current_speed;
	logic speed_trusted;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = REG_ACCEL_BAND0;
	logic [CfgDataW-1:0] cfg_data = '0;

	wire [SpeedW-1:0]  pulse_speed        = cur_word.pulse_speed;
	wire [SpeedW-1:0]  gps_speed          = cur_word.gps_speed;
	wire               gps_fixed          = cur_word.gps_fixed;
	wire [CourseW-1:0] course_deg         = cur_word.course_deg;
	wire               ignition_on        = cur_word.ignition_on;
	wire               navigation_ok      = cur_word.navigation_ok;
	wire               vehicle_moving     = cur_word.vehicle_moving;
	wire               obd_module_present = cur_word.obd_module_present;

	result_t seen_word;
	assign seen_word = {sharp_accel, sharp_decel, sharp_turn, current_speed, speed_trusted};

	harsh_driving_event_detector DUT (.*);

	// Predictor state and its copy of the limit registers.
	logic [SpeedW-1:0]   rise_base = '0;
	logic [SpeedW-1:0]   drop_base = '0;
	logic [CourseW-1:0]  last_heading = '0;
	logic                speed_ok = 1'b0;
	logic [FixCntW-1:0]  fix_run = '0;
	logic [SpeedW-1:0]   rise_lim [4] = '{default: '0};
	logic [SpeedW-1:0]   drop_lim_low = '0;
	logic [SpeedW-1:0]   drop_lim_high = '0;
	logic [TurnLimW-1:0] turn_lim = 16'd15;

	item_t pending_ticks [$];
	result_t expected_flags [$];

	int mismatch_count = 0;
	int idle_cycles = 0;
	int in_gap = 0;
	int stall_left = 0;
	int walk_speed = 0;
	int walk_heading = 0;
	int gps_run = 0;
	logic quiet = 1'b0;
	logic in_took = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [CourseW-1:0] heading_change(logic [CourseW-1:0] now_deg,
			logic [CourseW-1:0] was_deg);
		logic [CourseW-1:0] d;
		d = (now_deg >= was_deg) ? now_deg - was_deg : was_deg - now_deg;
		if (d < HalfCircle) begin
			return d;
		end
		if (d <= FullCircle) begin
			return FullCircle - d;
		end
		return '0;
	endfunction

	function automatic result_t score_tick(item_t w);
		result_t r;
		logic [SpeedW-1:0] spd;
		logic [1:0] band;
		logic [SpeedW-1:0] lim;
		r = '0;
		spd = (w.pulse_speed != '0) ? w.pulse_speed : w.gps_speed;
		if (!w.obd_module_present) begin
			if (w.pulse_speed != '0) begin
				speed_ok = 1'b1;
			end else if (!w.gps_fixed) begin
				fix_run = '0;
				speed_ok = 1'b0;
			end else if (!speed_ok) begin
				if (fix_run > 3'd5) begin
					speed_ok = 1'b1;
				end
				if (fix_run != 3'd7) begin
					fix_run = fix_run + 3'd1;
				end
			end
			if (rise_lim[0] != '0 && rise_lim[1] != '0 && rise_lim[2] != '0
					&& rise_lim[3] != '0) begin
				if (speed_ok && spd > rise_base && rise_base != '0) begin
					band = (rise_base >= 8'd90) ? 2'd3 : 2'(rise_base / 8'd30);
					r.sharp_accel = (spd - rise_base) >= rise_lim[band];
				end
				rise_base = spd;
			end
			if (drop_lim_low != '0 && drop_lim_high != '0) begin
				if (speed_ok && spd < drop_base && drop_base != '0) begin
					lim = (drop_base < 8'd30) ? drop_lim_low : drop_lim_high;
					r.sharp_decel = (drop_base - spd) >= lim;
				end
				drop_base = spd;
			end
			if (turn_lim != '0) begin
				if (w.ignition_on && w.navigation_ok && w.vehicle_moving) begin
					r.sharp_turn = ({7'd0, heading_change(w.course_deg, last_heading)} >= turn_lim)
						&& (spd > 8'd25);
				end
				last_heading = w.course_deg;
			end
		end
		r.current_speed = spd;
		r.speed_trusted = speed_ok;
		return r;
	endfunction

	function automatic item_t tick(int p, int g, bit fix, int c, bit [2:0] st, bit obd);
		item_t w;
		w.pulse_speed = 8'(p);
		w.gps_speed = 8'(g);
		w.gps_fixed = fix;
		w.course_deg = 9'(c);
		{w.ignition_on, w.navigation_ok, w.vehicle_moving} = st;
		w.obd_module_present = obd;
		return w;
	endfunction

	// Mostly a plausible drive: speed and heading follow random walks, with GPS-only stretches.
	function automatic item_t random_tick();
		item_t w;
		logic [31:0] noise;
		noise = $urandom;
		if ($urandom_range(0, 19) == 0) begin
			w = noise[29:0];
			return w;
		end
		if ($urandom_range(0, 9) == 0) begin
			walk_speed = int'($urandom_range(0, 255));
		end else begin
			walk_speed = walk_speed + int'($urandom_range(0, 50)) - 25;
		end
		if (walk_speed < 0) begin
			walk_speed = 0;
		end else if (walk_speed > 255) begin
			walk_speed = 255;
		end
		if ($urandom_range(0, 9) == 0) begin
			walk_heading = int'($urandom_range(0, 359));
		end else begin
			walk_heading = (walk_heading + int'($urandom_range(0, 90)) + 315) % 360;
		end
		if ($urandom_range(0, 15) == 0) begin
			w.course_deg = 9'($urandom_range(360, 511));
		end else begin
			w.course_deg = 9'(walk_heading);
		end
		if (gps_run > 0) begin
			gps_run--;
			w.pulse_speed = '0;
			w.gps_speed = 8'(walk_speed);
			w.gps_fixed = ($urandom_range(0, 11) != 0);
		end else begin
			if ($urandom_range(0, 15) == 0) begin
				gps_run = int'($urandom_range(4, 12));
			end
			w.pulse_speed = 8'(walk_speed);
			w.gps_speed = noise[7:0];
			w.gps_fixed = noise[8];
		end
		if ($urandom_range(0, 6) == 0) begin
			{w.ignition_on, w.navigation_ok, w.vehicle_moving} = noise[11:9];
		end else begin
			{w.ignition_on, w.navigation_ok, w.vehicle_moving} = 3'b111;
		end
		w.obd_module_present = ($urandom_range(0, 19) == 0);
		return w;
	endfunction

	function automatic logic [SpeedW-1:0] some_limit();
		return 8'($urandom_range(1, 40));
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ACCEL_BAND0, REG_ACCEL_BAND1, REG_ACCEL_BAND2, REG_ACCEL_BAND3: begin
				rise_lim[2'(idx)] = val[SpeedW-1:0];
			end
			REG_DECEL_LOW: begin
				drop_lim_low = val[SpeedW-1:0];
			end
			REG_DECEL_HIGH: begin
				drop_lim_high = val[SpeedW-1:0];
			end
			REG_TURN_LIMIT: begin
				turn_lim = val;
			end
			default: begin
			end
		endcase
	endtask

	task automatic program_limits(logic [SpeedW-1:0] r0, logic [SpeedW-1:0] r1,
			logic [SpeedW-1:0] r2, logic [SpeedW-1:0] r3, logic [SpeedW-1:0] d0,
			logic [SpeedW-1:0] d1, logic [TurnLimW-1:0] t);
		write_reg(REG_ACCEL_BAND0, {8'($urandom), r0});
		write_reg(REG_ACCEL_BAND1, {8'($urandom), r1});
		write_reg(REG_ACCEL_BAND2, {8'($urandom), r2});
		write_reg(REG_ACCEL_BAND3, {8'($urandom), r3});
		write_reg(REG_DECEL_LOW, {8'($urandom), d0});
		write_reg(REG_DECEL_HIGH, {8'($urandom), d1});
		write_reg(REG_TURN_LIMIT, t);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (pending_ticks.size() != 0 || in_valid || expected_flags.size() != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_ticks.size() != 0) begin
				cur_word <= pending_ticks.pop_front();
				in_valid <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0) begin
					in_gap = int'($urandom_range(1, 14));
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!quiet && stall_left == 0 && $urandom_range(0, 9) == 0) begin
			stall_left = int'($urandom_range(1, 14));
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		in_took <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			expected_flags.push_back(score_tick(cur_word));
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_flags.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("%0t: word with none expected: accel=%0b decel=%0b turn=%0b speed=%0d trusted=%0b",
						$time, seen_word.sharp_accel, seen_word.sharp_decel,
						seen_word.sharp_turn, seen_word.current_speed, seen_word.speed_trusted);
				end
			end else begin
				want = expected_flags.pop_front();
				if (seen_word.sharp_accel !== want.sharp_accel
						|| seen_word.sharp_decel !== want.sharp_decel
						|| seen_word.sharp_turn !== want.sharp_turn
						|| seen_word.current_speed !== want.current_speed
						|| seen_word.speed_trusted !== want.speed_trusted) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: expected accel=%0b decel=%0b turn=%0b speed=%0d trusted=%0b",
							$time, want.sharp_accel, want.sharp_decel, want.sharp_turn,
							want.current_speed, want.speed_trusted);
						$display("%0t:      got accel=%0b decel=%0b turn=%0b speed=%0d trusted=%0b",
							$time, seen_word.sharp_accel, seen_word.sharp_decel,
							seen_word.sharp_turn, seen_word.current_speed, seen_word.speed_trusted);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchdogLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : main
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset limits: both speed detectors are off and the turn limit is 15 degrees.
		repeat (20) pending_ticks.push_back(random_tick());
		wait_drained();

		program_limits(8'd5, 8'd10, 8'd15, 8'd20, 8'd8, 8'd12, 16'd30);
		repeat (7) pending_ticks.push_back(tick(0, 40, 1, 5, 3'b111, 0));
		pending_ticks.push_back(tick(0, 50, 1, 5, 3'b111, 0));
		pending_ticks.push_back(tick(0, 50, 0, 5, 3'b111, 0));
		pending_ticks.push_back(tick(20, 0, 0, 5, 3'b111, 0));
		pending_ticks.push_back(tick(25, 0, 0, 5, 3'b111, 0));
		pending_ticks.push_back(tick(255, 0, 1, 10, 3'b111, 0));
		pending_ticks.push_back(tick(0, 255, 1, 10, 3'b111, 0));
		pending_ticks.push_back(tick(100, 7, 0, 10, 3'b111, 0));
		pending_ticks.push_back(tick(100, 7, 0, 350, 3'b111, 0));
		pending_ticks.push_back(tick(100, 7, 0, 170, 3'b111, 0));
		pending_ticks.push_back(tick(100, 7, 0, 0, 3'b111, 0));
		pending_ticks.push_back(tick(100, 7, 0, 400, 3'b111, 0));
		pending_ticks.push_back(tick(100, 7, 0, 511, 3'b111, 0));
		pending_ticks.push_back(tick(0, 0, 1, 100, 3'b111, 0));
		pending_ticks.push_back(tick(24, 0, 1, 300, 3'b111, 0));
		pending_ticks.push_back(tick(26, 0, 1, 0, 3'b111, 0));
		pending_ticks.push_back(tick(26, 0, 1, 90, 3'b011, 0));
		pending_ticks.push_back(tick(200, 0, 1, 270, 3'b111, 1));
		pending_ticks.push_back(tick(26, 0, 1, 180, 3'b111, 0));
		wait_drained();

		for (int phase = 0; phase < RandomPhases; phase++) begin
			case (phase)
				0: begin
					program_limits(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF);
				end
				1: begin
					program_limits(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 16'd1);
				end
				2: begin
					program_limits(some_limit(), some_limit(), 8'd0, some_limit(),
						some_limit(), some_limit(), 16'd0);
				end
				3: begin
					program_limits(some_limit(), some_limit(), some_limit(), some_limit(),
						8'd0, some_limit(), 16'd200);
				end
				default: begin
					program_limits(some_limit(), some_limit(), some_limit(), some_limit(),
						some_limit(), some_limit(), 16'($urandom_range(1, 180)));
				end
			endcase
			if (phase == RandomPhases - 1) begin
				quiet = 1'b1;
			end
			repeat (PhaseTicks) pending_ticks.push_back(random_tick());
			wait_drained();
		end

		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/hde_pkg.sv
src/hde_cfg_regs.sv
src/hde_eval.sv
src/harsh_driving_event_detector.sv
test/tb.sv
